// ----- rtl/tpbp_pkg.sv -----
package tpbp_pkg;

  localparam int TPBP_BLOCK_BYTES = 65536;

  localparam logic [1:0] ACT_STORE   = 2'd0;
  localparam logic [1:0] ACT_BEGIN   = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  localparam logic [31:0] TAG_PULS = 32'h534C5550;
  localparam logic [31:0] TAG_PAUS = 32'h53554150;
  localparam logic [31:0] TAG_DATA = 32'h41544144;

  localparam logic [16:0] POS_LIMIT = 17'h10000;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PULS = 2'd1,
    MODE_PAUS = 2'd2,
    MODE_DATA = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] byte_index;
    logic [7:0]  byte_value;
    logic [23:0] ticks;
  } in_t;

  typedef struct packed {
    logic        tape_level;
    logic [23:0] leftover_ticks;
    logic        needs_block;
  } out_t;

endpackage

// ----- rtl/tape_pulse_block_player_top.sv -----
// Store and unused actions pass through S_FIN and deliver their result from a register.
// Begin fetches its tag and header words byte by byte from the registered block store.
// Advance steps through pulse edges, pulse word reads and data bit reads,
// paced by store reads and the single shared subtractor.
// Reset is synchronous and active low; the block store is undefined until written.
// One item is in work at a time; out_valid is high for one cycle, no receiver stall.
module tape_pulse_block_player_top import tpbp_pkg::*; #(
  parameter int BLOCK_BYTES = TPBP_BLOCK_BYTES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int AW = $clog2(BLOCK_BYTES);

  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_FIN     = 25'h0000002,
    S_FETCH   = 25'h0000004,
    S_B_TAG   = 25'h0000008,
    S_B_PULS  = 25'h0000010,
    S_B_PAUS  = 25'h0000020,
    S_B_D1    = 25'h0000040,
    S_B_D2    = 25'h0000080,
    S_LOOP    = 25'h0000100,
    S_P0      = 25'h0000200,
    S_P1      = 25'h0000400,
    S_P_DUR   = 25'h0000800,
    S_P_EXT   = 25'h0001000,
    S_P_CHK   = 25'h0002000,
    S_P_CONS  = 25'h0004000,
    S_P_SUB   = 25'h0008000,
    S_PA_CONS = 25'h0010000,
    S_PA_SUB  = 25'h0020000,
    S_D0      = 25'h0040000,
    S_DW_CONS = 25'h0080000,
    S_DW_SUB  = 25'h0100000,
    S_D_WL    = 25'h0200000,
    S_D_BIT   = 25'h0400000,
    S_DT_CONS = 25'h0800000,
    S_DT_SUB  = 25'h1000000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [16:0] fa_r, fa_nxt;
  logic [2:0]  fn_r, fn_nxt, k_r, k_nxt;
  logic        rok_r;
  logic [31:0] word_r, word_nxt;
  logic [23:0] t_r, t_nxt;
  mode_t       mode_r, mode_nxt;
  logic        level_r, level_nxt;
  logic [16:0] pulse_read_pos_r, pulse_read_pos_nxt;
  logic [16:0] pulse_block_end_r, pulse_block_end_nxt;
  logic [14:0] pulse_repeats_r, pulse_repeats_nxt;
  logic [30:0] pulse_length_r, pulse_length_nxt;
  logic [30:0] pulse_left_r, pulse_left_nxt;
  logic [30:0] pause_left_r, pause_left_nxt;
  logic [30:0] bits_left_r, bits_left_nxt;
  logic [15:0] tail_left_r, tail_left_nxt;
  logic [7:0]  zero_wave_count_r, zero_wave_count_nxt;
  logic [7:0]  one_wave_count_r, one_wave_count_nxt;
  logic [7:0]  wave_pulses_left_r, wave_pulses_left_nxt;
  logic [15:0] wave_table_pos_r, wave_table_pos_nxt;
  logic [15:0] bit_byte_pos_r, bit_byte_pos_nxt;
  logic [7:0]  bit_mask_r, bit_mask_nxt;
  logic [15:0] wave_left_r, wave_left_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  logic        accept;
  logic        ram_we;
  logic [16:0] rd_addr;
  logic        rd_ok;
  logic [7:0]  ram_rdata;
  logic [31:0] sub_a, sub_b, sub_diff;
  logic        sub_gt;
  logic [1:0]  kcap;
  logic [16:0] pos_step;
  logic [16:0] pos_inc;
  logic [15:0] wtp_step;
  logic [7:0]  wpl_dec;
  logic [14:0] rep_dec;
  logic [7:0]  mask_shift;
  logic        data_bit;
  logic [7:0]  wpl_sel;
  logic [15:0] wtp_sel;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign ram_we  = accept && (in_data.action == ACT_STORE) &&
                   (32'(in_data.byte_index) < 32'(BLOCK_BYTES));
  assign rd_addr = fa_r + 17'(k_r);
  assign rd_ok   = (32'(rd_addr) < 32'(BLOCK_BYTES));
  assign kcap    = 2'(k_r - 3'd1);

  assign pos_inc    = pulse_read_pos_r + 17'd2;
  assign pos_step   = (pos_inc > POS_LIMIT) ? POS_LIMIT : pos_inc;
  assign wtp_step   = wave_table_pos_r + 16'd2;
  assign wpl_dec    = wave_pulses_left_r - 8'd1;
  assign rep_dec    = pulse_repeats_r - 15'd1;
  assign mask_shift = bit_mask_r >> 1;
  assign data_bit   = |(word_r[7:0] & bit_mask_r);
  assign wpl_sel    = data_bit ? one_wave_count_r : zero_wave_count_r;
  assign wtp_sel    = data_bit ? (16'd16 + {7'd0, zero_wave_count_r, 1'b0}) : 16'd16;

  tpbp_ram #(
    .WIDTH(8),
    .DEPTH(BLOCK_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_data.byte_index)),
    .wdata(in_data.byte_value),
    .raddr(AW'(rd_addr)),
    .rdata(ram_rdata)
  );

  tpbp_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .diff(sub_diff),
    .gt  (sub_gt)
  );

  always_comb begin
    sub_a = {1'b0, pulse_left_r};
    sub_b = {8'd0, t_r};
    unique case (state_r)
      S_P_SUB: begin
        sub_a = {8'd0, t_r};
        sub_b = {1'b0, pulse_left_r};
      end
      S_PA_CONS: begin
        sub_a = {1'b0, pause_left_r};
        sub_b = {8'd0, t_r};
      end
      S_PA_SUB: begin
        sub_a = {8'd0, t_r};
        sub_b = {1'b0, pause_left_r};
      end
      S_DW_CONS: begin
        sub_a = {16'd0, wave_left_r};
        sub_b = {8'd0, t_r};
      end
      S_DW_SUB: begin
        sub_a = {8'd0, t_r};
        sub_b = {16'd0, wave_left_r};
      end
      S_DT_CONS: begin
        sub_a = {16'd0, tail_left_r};
        sub_b = {8'd0, t_r};
      end
      S_DT_SUB: begin
        sub_a = {8'd0, t_r};
        sub_b = {16'd0, tail_left_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt            = state_r;
    ret_nxt              = ret_r;
    fa_nxt               = fa_r;
    fn_nxt               = fn_r;
    k_nxt                = k_r;
    word_nxt             = word_r;
    t_nxt                = t_r;
    mode_nxt             = mode_r;
    level_nxt            = level_r;
    pulse_read_pos_nxt   = pulse_read_pos_r;
    pulse_block_end_nxt  = pulse_block_end_r;
    pulse_repeats_nxt    = pulse_repeats_r;
    pulse_length_nxt     = pulse_length_r;
    pulse_left_nxt       = pulse_left_r;
    pause_left_nxt       = pause_left_r;
    bits_left_nxt        = bits_left_r;
    tail_left_nxt        = tail_left_r;
    zero_wave_count_nxt  = zero_wave_count_r;
    one_wave_count_nxt   = one_wave_count_r;
    wave_pulses_left_nxt = wave_pulses_left_r;
    wave_table_pos_nxt   = wave_table_pos_r;
    bit_byte_pos_nxt     = bit_byte_pos_r;
    bit_mask_nxt         = bit_mask_r;
    wave_left_nxt        = wave_left_r;
    out_valid_nxt        = 1'b0;
    out_nxt              = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          t_nxt     = 24'd0;
          state_nxt = S_FIN;
          if (in_data.action == ACT_BEGIN) begin
            fa_nxt    = 17'd0;
            fn_nxt    = 3'd4;
            k_nxt     = 3'd0;
            word_nxt  = 32'd0;
            ret_nxt   = S_B_TAG;
            state_nxt = S_FETCH;
          end else if (in_data.action == ACT_ADVANCE) begin
            t_nxt     = in_data.ticks;
            state_nxt = S_LOOP;
          end
        end
      end
      S_FIN: begin
        out_valid_nxt          = 1'b1;
        out_nxt.tape_level     = level_r;
        out_nxt.leftover_ticks = t_r;
        out_nxt.needs_block    = (mode_r == MODE_IDLE);
        state_nxt              = S_IDLE;
      end
      S_FETCH: begin
        if (k_r != 3'd0) begin
          word_nxt[{kcap, 3'b000} +: 8] = rok_r ? ram_rdata : 8'd0;
        end
        if (k_r == fn_r) begin
          state_nxt = ret_r;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_B_TAG: begin
        state_nxt = S_FIN;
        fn_nxt    = 3'd4;
        k_nxt     = 3'd0;
        if (word_r == TAG_PULS) begin
          fa_nxt    = 17'd4;
          word_nxt  = 32'd0;
          ret_nxt   = S_B_PULS;
          state_nxt = S_FETCH;
        end else if (word_r == TAG_PAUS) begin
          fa_nxt    = 17'd8;
          word_nxt  = 32'd0;
          ret_nxt   = S_B_PAUS;
          state_nxt = S_FETCH;
        end else if (word_r == TAG_DATA) begin
          fa_nxt    = 17'd8;
          word_nxt  = 32'd0;
          ret_nxt   = S_B_D1;
          state_nxt = S_FETCH;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      S_B_PULS: begin
        mode_nxt            = MODE_PULS;
        pulse_block_end_nxt = (word_r >= 32'h0000FFF8) ? POS_LIMIT :
                              17'(word_r + 32'd8);
        pulse_read_pos_nxt  = 17'd8;
        pulse_repeats_nxt   = 15'd0;
        pulse_left_nxt      = 31'd0;
        pulse_length_nxt    = 31'd0;
        level_nxt           = 1'b0;
        state_nxt           = S_FIN;
      end
      S_B_PAUS: begin
        mode_nxt       = MODE_PAUS;
        level_nxt      = word_r[31];
        pause_left_nxt = word_r[30:0];
        state_nxt      = S_FIN;
      end
      S_B_D1: begin
        level_nxt     = word_r[31];
        bits_left_nxt = word_r[30:0];
        fa_nxt        = 17'd12;
        fn_nxt        = 3'd4;
        k_nxt         = 3'd0;
        word_nxt      = 32'd0;
        ret_nxt       = S_B_D2;
        state_nxt     = S_FETCH;
      end
      S_B_D2: begin
        mode_nxt             = MODE_DATA;
        tail_left_nxt        = word_r[15:0];
        zero_wave_count_nxt  = word_r[23:16];
        one_wave_count_nxt   = word_r[31:24];
        wave_pulses_left_nxt = 8'd0;
        wave_table_pos_nxt   = 16'd16;
        wave_left_nxt        = 16'd0;
        bit_byte_pos_nxt     = 16'd16 +
                               {6'd0, ({1'b0, word_r[23:16]} + {1'b0, word_r[31:24]}), 1'b0};
        bit_mask_nxt         = 8'h80;
        if (word_r[31:16] == 16'd0) begin
          bits_left_nxt = 31'd0;
        end
        state_nxt = S_FIN;
      end
      S_LOOP: begin
        if ((t_r == 24'd0) || (mode_r == MODE_IDLE)) begin
          state_nxt = S_FIN;
        end else begin
          unique case (mode_r)
            MODE_PULS: state_nxt = S_P0;
            MODE_PAUS: state_nxt = S_PA_CONS;
            MODE_DATA: state_nxt = S_D0;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_P0: begin
        if (pulse_repeats_r != 15'd0) begin
          state_nxt = S_P_CONS;
        end else if (pulse_read_pos_r >= pulse_block_end_r) begin
          mode_nxt  = MODE_IDLE;
          state_nxt = S_LOOP;
        end else begin
          fa_nxt             = pulse_read_pos_r;
          pulse_read_pos_nxt = pos_step;
          fn_nxt             = 3'd2;
          k_nxt              = 3'd0;
          word_nxt           = 32'd0;
          ret_nxt            = S_P1;
          state_nxt          = S_FETCH;
        end
      end
      S_P1: begin
        pulse_repeats_nxt = 15'd1;
        state_nxt         = S_P_DUR;
        if (word_r[15:0] > 16'h8000) begin
          pulse_repeats_nxt  = word_r[14:0];
          fa_nxt             = pulse_read_pos_r;
          pulse_read_pos_nxt = pos_step;
          fn_nxt             = 3'd2;
          k_nxt              = 3'd0;
          word_nxt           = 32'd0;
          ret_nxt            = S_P_DUR;
          state_nxt          = S_FETCH;
        end
      end
      S_P_DUR: begin
        if (word_r[15]) begin
          pulse_length_nxt   = {word_r[14:0], 16'd0};
          fa_nxt             = pulse_read_pos_r;
          pulse_read_pos_nxt = pos_step;
          fn_nxt             = 3'd2;
          k_nxt              = 3'd0;
          word_nxt           = 32'd0;
          ret_nxt            = S_P_EXT;
          state_nxt          = S_FETCH;
        end else begin
          pulse_length_nxt = {15'd0, word_r[15:0]};
          pulse_left_nxt   = {15'd0, word_r[15:0]};
          state_nxt        = S_P_CHK;
        end
      end
      S_P_EXT: begin
        pulse_length_nxt = {pulse_length_r[30:16], word_r[15:0]};
        pulse_left_nxt   = {pulse_length_r[30:16], word_r[15:0]};
        state_nxt        = S_P_CHK;
      end
      S_P_CHK: begin
        state_nxt = (pulse_repeats_r == 15'd0) ? S_LOOP : S_P_CONS;
      end
      S_P_CONS: begin
        if (sub_gt) begin
          pulse_left_nxt = sub_diff[30:0];
          t_nxt          = 24'd0;
          state_nxt      = S_LOOP;
        end else begin
          state_nxt = S_P_SUB;
        end
      end
      S_P_SUB: begin
        t_nxt             = sub_diff[23:0];
        pulse_repeats_nxt = rep_dec;
        level_nxt         = !level_r;
        if (rep_dec != 15'd0) begin
          pulse_left_nxt = pulse_length_r;
        end else begin
          pulse_left_nxt = 31'd0;
          if (pulse_read_pos_r >= pulse_block_end_r) begin
            mode_nxt = MODE_IDLE;
          end
        end
        state_nxt = S_LOOP;
      end
      S_PA_CONS: begin
        if (sub_gt) begin
          pause_left_nxt = sub_diff[30:0];
          t_nxt          = 24'd0;
          state_nxt      = S_LOOP;
        end else begin
          state_nxt = S_PA_SUB;
        end
      end
      S_PA_SUB: begin
        t_nxt          = sub_diff[23:0];
        pause_left_nxt = 31'd0;
        mode_nxt       = MODE_IDLE;
        state_nxt      = S_LOOP;
      end
      S_D0: begin
        if (wave_pulses_left_r != 8'd0) begin
          state_nxt = S_DW_CONS;
        end else if (bits_left_r != 31'd0) begin
          fa_nxt    = {1'b0, bit_byte_pos_r};
          fn_nxt    = 3'd1;
          k_nxt     = 3'd0;
          word_nxt  = 32'd0;
          ret_nxt   = S_D_BIT;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_DT_CONS;
        end
      end
      S_DW_CONS: begin
        if (sub_gt) begin
          wave_left_nxt = sub_diff[15:0];
          t_nxt         = 24'd0;
          state_nxt     = S_LOOP;
        end else begin
          state_nxt = S_DW_SUB;
        end
      end
      S_DW_SUB: begin
        t_nxt                = sub_diff[23:0];
        level_nxt            = !level_r;
        wave_pulses_left_nxt = wpl_dec;
        wave_table_pos_nxt   = wtp_step;
        if (wpl_dec != 8'd0) begin
          fa_nxt    = {1'b0, wtp_step};
          fn_nxt    = 3'd2;
          k_nxt     = 3'd0;
          word_nxt  = 32'd0;
          ret_nxt   = S_D_WL;
          state_nxt = S_FETCH;
        end else begin
          wave_left_nxt = 16'd0;
          state_nxt     = S_LOOP;
        end
      end
      S_D_WL: begin
        wave_left_nxt = word_r[15:0];
        state_nxt     = S_LOOP;
      end
      S_D_BIT: begin
        if (mask_shift == 8'd0) begin
          bit_mask_nxt     = 8'h80;
          bit_byte_pos_nxt = bit_byte_pos_r + 16'd1;
        end else begin
          bit_mask_nxt = mask_shift;
        end
        bits_left_nxt        = bits_left_r - 31'd1;
        wave_pulses_left_nxt = wpl_sel;
        wave_table_pos_nxt   = wtp_sel;
        if (wpl_sel != 8'd0) begin
          fa_nxt    = {1'b0, wtp_sel};
          fn_nxt    = 3'd2;
          k_nxt     = 3'd0;
          word_nxt  = 32'd0;
          ret_nxt   = S_D_WL;
          state_nxt = S_FETCH;
        end else begin
          wave_left_nxt = 16'd0;
          state_nxt     = S_LOOP;
        end
      end
      S_DT_CONS: begin
        if (sub_gt) begin
          tail_left_nxt = sub_diff[15:0];
          t_nxt         = 24'd0;
          state_nxt     = S_LOOP;
        end else begin
          state_nxt = S_DT_SUB;
        end
      end
      S_DT_SUB: begin
        t_nxt         = sub_diff[23:0];
        tail_left_nxt = 16'd0;
        mode_nxt      = MODE_IDLE;
        state_nxt     = S_LOOP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      ret_r              <= S_IDLE;
      fa_r               <= 17'd0;
      fn_r               <= 3'd0;
      k_r                <= 3'd0;
      rok_r              <= 1'b0;
      t_r                <= 24'd0;
      mode_r             <= MODE_IDLE;
      level_r            <= 1'b0;
      pulse_read_pos_r   <= 17'd0;
      pulse_block_end_r  <= 17'd0;
      pulse_repeats_r    <= 15'd0;
      pulse_length_r     <= 31'd0;
      pulse_left_r       <= 31'd0;
      pause_left_r       <= 31'd0;
      bits_left_r        <= 31'd0;
      tail_left_r        <= 16'd0;
      zero_wave_count_r  <= 8'd0;
      one_wave_count_r   <= 8'd0;
      wave_pulses_left_r <= 8'd0;
      wave_table_pos_r   <= 16'd16;
      bit_byte_pos_r     <= 16'd0;
      bit_mask_r         <= 8'h80;
      wave_left_r        <= 16'd0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r            <= state_nxt;
      ret_r              <= ret_nxt;
      fa_r               <= fa_nxt;
      fn_r               <= fn_nxt;
      k_r                <= k_nxt;
      rok_r              <= rd_ok;
      t_r                <= t_nxt;
      mode_r             <= mode_nxt;
      level_r            <= level_nxt;
      pulse_read_pos_r   <= pulse_read_pos_nxt;
      pulse_block_end_r  <= pulse_block_end_nxt;
      pulse_repeats_r    <= pulse_repeats_nxt;
      pulse_length_r     <= pulse_length_nxt;
      pulse_left_r       <= pulse_left_nxt;
      pause_left_r       <= pause_left_nxt;
      bits_left_r        <= bits_left_nxt;
      tail_left_r        <= tail_left_nxt;
      zero_wave_count_r  <= zero_wave_count_nxt;
      one_wave_count_r   <= one_wave_count_nxt;
      wave_pulses_left_r <= wave_pulses_left_nxt;
      wave_table_pos_r   <= wave_table_pos_nxt;
      bit_byte_pos_r     <= bit_byte_pos_nxt;
      bit_mask_r         <= bit_mask_nxt;
      wave_left_r        <= wave_left_nxt;
      out_valid_r        <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/tpbp_ram.sv -----
module tpbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tpbp_sub.sv -----
module tpbp_sub import tpbp_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] diff,
  output logic        gt
);

  logic [32:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[31:0];
  assign gt   = !full[32] && (full[31:0] != 32'd0);

endmodule
